FILE: src/ab6_pkg.sv
// Shared types, constants and coefficient table of the sixth-order
// Adams-Bashforth integrator core. No dependencies.
`default_nettype none
package ab6_pkg;

   localparam int AB6_DIM       = 64;
   localparam int AB6_HISTORY   = 6;
   localparam int AB6_HIST_BITS = 32 * AB6_HISTORY;
   localparam int AB6_WEIGHT_DEN = 1440;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_PRIME = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   localparam logic [31:0] STEP_H_RESET = 32'h0001_0000;

   typedef struct packed {
      logic [1:0]         action;
      logic [5:0]         component;
      logic signed [31:0] value;
   } ab6_req_type;

   typedef struct packed {
      logic [5:0]         component_out;
      logic signed [31:0] state_out;
      logic               saturated;
   } ab6_rsp_type;

   typedef enum logic [2:0] {
      OP_IGNORE,
      OP_LOAD,
      OP_PRIME,
      OP_STEP,
      OP_QUERY
   } ab6_op_type;

   typedef struct packed {
      ab6_op_type         op;
      logic [5:0]         component;
      logic signed [31:0] value;
   } ab6_cmd_type;

   // Front to back: head of the command queue.
   typedef struct packed {
      logic        valid;
      ab6_cmd_type cmd;
   } ab6_link_type;

   // Back to front: flow control and reset sweep status.
   typedef struct packed {
      logic take;
      logic init_busy;
   } ab6_back_status_type;

   // Numerators of the coefficients, oldest derivative first.
   function automatic logic signed [14:0] ab6_weight(input logic [2:0] k);
      logic signed [14:0] w;
      case (k)
         3'd0:    w = -15'sd475;
         3'd1:    w = 15'sd2877;
         3'd2:    w = -15'sd7298;
         3'd3:    w = 15'sd9982;
         3'd4:    w = -15'sd7923;
         3'd5:    w = 15'sd4277;
         default: w = 15'sd0;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: src/ab6_front.sv
// Front end of the integrator: accepts request items, classifies them into
// commands and holds them in a two-entry queue. Depends on ab6_pkg.
`default_nettype none
module ab6_front import ab6_pkg::*; #(
   parameter int DIM = AB6_DIM
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  ab6_req_type         req_item,
   input  ab6_back_status_type back_status,
   output ab6_link_type        link
);

   localparam logic [12:0] DIM_L = 13'(DIM);

   ab6_cmd_type q_ff [2];
   ab6_cmd_type q_in [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   ab6_cmd_type cmd_new;
   logic        in_range;
   logic        do_push, do_pop;

   always_comb begin
      in_range = {7'd0, req_item.component} < DIM_L;
      cmd_new.component = req_item.component;
      cmd_new.value     = req_item.value;
      if (!in_range) begin
         cmd_new.op = OP_IGNORE;
      end else begin
         case (req_item.action)
            ACT_LOAD:  cmd_new.op = OP_LOAD;
            ACT_PRIME: cmd_new.op = OP_PRIME;
            ACT_STEP:  cmd_new.op = OP_STEP;
            default:   cmd_new.op = OP_QUERY;
         endcase
      end
   end

   assign req_full = (count_ff == 2'd2) || back_status.init_busy;
   assign do_push  = req_push && !req_full;
   assign do_pop   = link.valid && back_status.take;
   assign link.valid = (count_ff != 2'd0);
   assign link.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      q_in = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         q_in[wr_ptr_ff] = cmd_new;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/ab6_back.sv
// Back end of the integrator: state and history memories, the sequential
// multiply-accumulate, divide-by-1440 and scaling datapath, and the result
// register. Depends on ab6_pkg.
`default_nettype none
module ab6_back import ab6_pkg::*; #(
   parameter int DIM = AB6_DIM
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [31:0]         step_h,
   input  ab6_link_type        link,
   output ab6_back_status_type back_status,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output ab6_rsp_type         rsp_item
);

   localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);
   localparam logic [11:0] DEN = 12'(AB6_WEIGHT_DEN);
   localparam logic [47:0] HALF_DEN = 48'(AB6_WEIGHT_DEN / 2);
   // ceil(2^37 / 1440); exact quotient for any partial dividend below 1440 * 2^16.
   localparam logic [26:0] DIV_RECIP = 27'd95443718;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_MAC, S_ABS, S_DIV, S_REM,
      S_MUL_LO, S_MUL_HI, S_SUM, S_FIN, S_OUT
   } state_type;

   logic [31:0]              state_mem [DIM];
   logic [AB6_HIST_BITS-1:0] hist_mem  [DIM];

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         clr_ff, clr_in;
   ab6_cmd_type              cmd_ff, cmd_in;
   logic [31:0]              st_rd_ff;
   logic [AB6_HIST_BITS-1:0] hist_rd_ff;
   logic [AB6_HIST_BITS-1:0] row_ff, row_in;
   logic [2:0]               k_ff, k_in;
   logic signed [47:0]       acc_ff, acc_in;
   logic                     neg_w_ff, neg_w_in;
   logic [47:0]              dvd_ff, dvd_in;
   logic [10:0]              rem_ff, rem_in;
   logic [35:0]              quo_ff, quo_in;
   logic [15:0]              digit_ff, digit_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic [63:0]              plo_ff, plo_in;
   logic [35:0]              phi_ff, phi_in;
   logic signed [53:0]       delta_ff, delta_in;
   ab6_rsp_type              res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ab6_rsp_type              rsp_ff, rsp_in;

   logic                     rd_en;
   logic [11:0]              rd_ext, cmd_ext;
   logic [IDX_W-1:0]         rd_addr, cmd_addr;
   logic                     state_we;
   logic [31:0]              state_wdata;
   logic                     hist_we;
   logic [IDX_W-1:0]         hist_waddr;
   logic [AB6_HIST_BITS-1:0] hist_wdata;
   logic [AB6_HIST_BITS-1:0] new_row;
   logic signed [46:0]       prod;
   logic [26:0]              trial;
   logic [53:0]              recip_prod;
   logic [26:0]              rem_calc;
   logic                     neg_h;
   logic [31:0]              mh;
   logic [52:0]              mag;
   logic [64:0]              lo_round;
   logic signed [54:0]       nv;

   assign rd_ext   = {6'd0, link.cmd.component};
   assign rd_addr  = rd_ext[IDX_W-1:0];
   assign cmd_ext  = {6'd0, cmd_ff.component};
   assign cmd_addr = cmd_ext[IDX_W-1:0];
   assign rd_en    = (state_ff == S_IDLE) && link.valid;
   assign new_row  = {cmd_ff.value, hist_rd_ff[AB6_HIST_BITS-1:32]};
   assign prod     = $signed(row_ff[31:0]) * ab6_weight(k_ff);
   assign trial    = {rem_ff, dvd_ff[47:32]};
   assign recip_prod = {27'd0, trial} * {27'd0, DIV_RECIP};
   assign rem_calc = trial - ({11'd0, digit_ff} * {15'd0, DEN});
   assign neg_h    = step_h[31];
   assign mh       = neg_h ? (32'd0 - step_h) : step_h;
   assign lo_round = {1'b0, plo_ff} + 65'h8000;
   assign mag      = {1'b0, phi_ff, 16'd0} + {4'd0, lo_round[64:16]};
   assign nv       = 55'($signed(st_rd_ff)) + 55'(delta_ff);

   assign back_status.take      = rd_en;
   assign back_status.init_busy = (state_ff == S_CLEAR);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cmd_in   = cmd_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      neg_w_in = neg_w_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      digit_in = digit_ff;
      cnt_in   = cnt_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      delta_in = delta_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      state_we    = 1'b0;
      state_wdata = cmd_ff.value;
      hist_we     = 1'b0;
      hist_waddr  = cmd_addr;
      hist_wdata  = new_row;
      case (state_ff)
         S_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wdata = '0;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (link.valid) begin
               cmd_in   = link.cmd;
               state_in = S_READ;
            end
         end
         S_READ: begin
            res_in.component_out = cmd_ff.component;
            res_in.saturated     = 1'b0;
            res_in.state_out     = st_rd_ff;
            state_in             = S_OUT;
            case (cmd_ff.op)
               OP_IGNORE: res_in.state_out = '0;
               OP_LOAD: begin
                  state_we         = 1'b1;
                  res_in.state_out = cmd_ff.value;
               end
               OP_PRIME: hist_we = 1'b1;
               OP_STEP: begin
                  hist_we  = 1'b1;
                  row_in   = new_row;
                  acc_in   = '0;
                  k_in     = '0;
                  state_in = S_MAC;
               end
               default: ;
            endcase
         end
         S_MAC: begin
            acc_in = acc_ff + 48'(prod);
            row_in = row_ff >> 32;
            k_in   = k_ff + 3'd1;
            if (k_ff == 3'(AB6_HISTORY - 1)) begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            neg_w_in = acc_ff[47];
            dvd_in   = (acc_ff[47] ? (48'd0 - acc_ff) : acc_ff) + HALF_DEN;
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // Long division by 1440 in 16-bit digits: the digit comes from
            // a reciprocal multiplication of the partial dividend.
            digit_in = recip_prod[52:37];
            state_in = S_REM;
         end
         S_REM: begin
            rem_in = rem_calc[10:0];
            quo_in = {quo_ff[19:0], digit_ff};
            dvd_in = dvd_ff << 16;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               state_in = S_MUL_LO;
            end else begin
               state_in = S_DIV;
            end
         end
         S_MUL_LO: begin
            plo_in   = quo_ff[31:0] * mh;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            phi_in   = quo_ff[35:32] * mh;
            state_in = S_SUM;
         end
         S_SUM: begin
            delta_in = (neg_w_ff != neg_h) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            state_in = S_FIN;
         end
         S_FIN: begin
            state_we = 1'b1;
            if (nv > 55'sh7FFF_FFFF) begin
               state_wdata      = 32'h7FFF_FFFF;
               res_in.saturated = 1'b1;
            end else if (nv < -55'sh8000_0000) begin
               state_wdata      = 32'h8000_0000;
               res_in.saturated = 1'b1;
            end else begin
               state_wdata      = nv[31:0];
               res_in.saturated = 1'b0;
            end
            res_in.state_out = state_wdata;
            state_in         = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         st_rd_ff   <= state_mem[rd_addr];
         hist_rd_ff <= hist_mem[rd_addr];
      end
      if (state_we) begin
         state_mem[cmd_addr] <= state_wdata;
      end
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      row_ff   <= row_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      neg_w_ff <= neg_w_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      digit_ff <= digit_in;
      cnt_ff   <= cnt_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      delta_ff <= delta_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/adams_bashforth6_integrator_core.sv
// Top level of the sixth-order Adams-Bashforth integrator core.
// Depends on ab6_pkg, ab6_front and ab6_back.
`default_nettype none
// The core keeps, for each of DIM vector components, a Q16.16 state value and
// the six most recent derivatives. Each request item loads a state, primes the
// history with a derivative, queries the state, or steps: it shifts in a new
// derivative and adds h times the rounded Adams-Bashforth weighted sum to the
// state, saturating to 32 bits. Every item returns exactly one result item
// with the component's state. Items for a component at or beyond DIM are
// ignored and report zero. After reset the derivative history is cleared one
// component per cycle, and req_full stays high until the clear is done; the
// state store is not cleared and must be loaded before it is stepped or primed.
// A front queue of two items takes requests while the back end works. The back
// end handles one item at a time and takes an item from the queue once it is
// registered there and the back end is idle. A load, prime, query or ignored
// item passes through the read and output states; a step runs the
// multiply-accumulate over the six derivatives, division by 1440 (three 16-bit
// digits, each found by reciprocal multiplication and then reduced to a
// remainder) and the scaling, rounding and saturation steps. A result that
// is not popped holds the back end until the result register is free. The
// step size step_h is written through csr_we and must only change while the
// core is idle.
module adams_bashforth6_integrator_core import ab6_pkg::*; #(
   parameter int DIM = AB6_DIM
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_push,
   output logic         req_full,
   input  ab6_req_type  req_item,
   output logic         rsp_empty,
   input  wire          rsp_pop,
   output ab6_rsp_type  rsp_item,
   input  wire          csr_we,
   input  wire  [31:0]  csr_wdata
);

   logic [31:0]         step_h_ff, step_h_in;
   ab6_link_type        link;
   ab6_back_status_type back_status;

   // The step size register; a negative step size integrates backward.
   assign step_h_in = csr_we ? csr_wdata : step_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_h_ff <= STEP_H_RESET;
      end else begin
         step_h_ff <= step_h_in;
      end
   end

   ab6_front #(.DIM(DIM)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_item    (req_item),
      .back_status (back_status),
      .link        (link)
   );

   ab6_back #(.DIM(DIM)) u_back (
      .clock       (clock),
      .reset       (reset),
      .step_h      (step_h_ff),
      .link        (link),
      .back_status (back_status),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_item    (rsp_item)
   );

   // While the history is being cleared, no command can be queued and no
   // result can be pending.
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      back_status.init_busy |-> (!link.valid && rsp_empty && req_full))
      else $error("item in flight during history clear");

   // A saturated result always sits at one of the two clamp limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.saturated) |->
         (rsp_item.state_out == 32'sh7FFF_FFFF || rsp_item.state_out == -32'sh8000_0000))
      else $error("saturated result not at a limit");

   // The back end never dequeues a command while the front queue is empty.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      back_status.take |-> link.valid)
      else $error("dequeue from empty command queue");

endmodule
`default_nettype wire
